[sv/piecewise_linear_inverse_lookup_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear inverse lookup
// Shared forms of the concurrent checks used by the RTL.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INVERSE_LOOKUP_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INVERSE_LOOKUP_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLIV_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLIV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pliv_pkg.sv]
// ----------------------------------------------------------------------------
// Piecewise linear inverse lookup package
// Item types, field widths and command codes shared by the lookup RTL.
// ----------------------------------------------------------------------------
package pliv_pkg;

   // Default number of knots held in the table.
   localparam int TABLE_DEPTH_DEF = 64;

   // Width of the segment count register and of the entry index field.
   localparam int CNT_W = 6;

   // Reset value of the segment count register.
   localparam logic [CNT_W-1:0] SEGMENT_COUNT_RST = 6'd1;

   // Quotient steps of the divider, one bit each.
   localparam int DIV_STEPS = 64;

   // Command codes carried in the func field.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // One input item.
   typedef struct packed {
      logic               func;
      logic [CNT_W-1:0]   entry_index;
      logic signed [31:0] entry_x;
      logic signed [31:0] entry_y;
      logic signed [31:0] query_point;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [31:0] result_value;
      logic               found;
      logic               divide_error;
   } rsp_type;

   // One knot as stored in the table.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } knot_type;

endpackage

[sv/pliv_div.sv]
// ----------------------------------------------------------------------------
// Piecewise linear inverse lookup divider
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module pliv_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic [63:0] quotient,
   output logic        done
);

   localparam int STEP_W = $clog2(pliv_pkg::DIV_STEPS + 1);

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff,  cnt_in;
   logic [63:0]       dq_ff,   dq_in;
   logic [31:0]       rem_ff,  rem_in;
   logic [32:0]       shifted;
   logic [32:0]       diff;
   logic              qbit;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      shifted = {rem_ff, dq_ff[63]};
      diff    = shifted - {1'b0, divisor};
      qbit    = (shifted >= {1'b0, divisor});
   end

   // Step sequencing.
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = STEP_W'(pliv_pkg::DIV_STEPS);
         dq_in  = dividend;
         rem_in = '0;
      end else if (run_ff) begin
         dq_in  = {dq_ff[62:0], qbit};
         rem_in = qbit ? diff[31:0] : shifted[31:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
   end

   assign quotient = dq_ff;
   assign done     = done_ff;

endmodule

[sv/piecewise_linear_inverse_lookup_top.sv]
// A write item is absorbed at its accepting edge and gives no result. A query
// that stops at knot K strobes its result after the table scan up to knot K,
// the setup states (difference, multiply, issue), the divider steps and the
// result register. A miss at knot L strobes from the scan, a flat one from ST_DIFF.
// Throughput: one item at a time; busy is low again in the result strobe cycle.
// Reset: synchronous, active high; segment count 1, knot table undefined until written.
// ----------------------------------------------------------------------------
// Piecewise linear inverse lookup top level
// Holds a knot table, scans it for the segment that brackets a query point
// and interpolates the output coordinate with a shared multiply and divide.
// ----------------------------------------------------------------------------
`include "piecewise_linear_inverse_lookup_top_defines.svh"

module piecewise_linear_inverse_lookup_top #(
   parameter int TABLE_DEPTH = pliv_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  pliv_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output pliv_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [pliv_pkg::CNT_W-1:0]     csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   // One bit more than either index so that TABLE_DEPTH itself fits.
   localparam int CMP_W = ((IDX_W > pliv_pkg::CNT_W) ? IDX_W : pliv_pkg::CNT_W) + 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FETCH = 7'b0000010,
      ST_SCAN  = 7'b0000100,
      ST_DIFF  = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_ISSUE = 7'b0100000,
      ST_DIV   = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [pliv_pkg::CNT_W-1:0]  seg_cnt_ff;
   logic [IDX_W-1:0]            last_ff, last_in;
   logic [IDX_W-1:0]            rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]            row_idx_ff;
   pliv_pkg::knot_type          row_ff;
   pliv_pkg::knot_type          prev_ff, prev_in;
   pliv_pkg::knot_type          cur_ff, cur_in;
   logic signed [31:0]          pt_ff, pt_in;
   logic                        found_ff, found_in;
   logic                        derr_ff, derr_in;
   logic [31:0]                 mag_num_ff, mag_num_in;
   logic [31:0]                 mag_dx_ff, mag_dx_in;
   logic [31:0]                 mag_dy_ff, mag_dy_in;
   logic                        neg_ff, neg_in;
   logic [63:0]                 prod_ff, prod_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pliv_pkg::rsp_type           rsp_ff, rsp_in;
   pliv_pkg::knot_type          mem [TABLE_DEPTH];

   logic                        accept;
   logic                        wr_en;
   logic [CMP_W-1:0]            wr_idx_ext;
   logic [CMP_W-1:0]            last_ext;
   logic signed [32:0]          num33, dx33, dy33;
   logic [32:0]                 num_abs, dx_abs, dy_abs;
   logic [63:0]                 quotient;
   logic                        div_done;
   logic                        q_big;
   logic signed [34:0]          sum35;
   logic signed [31:0]          sat_val;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Table write decode; an index past the table is dropped.
   always_comb begin
      wr_idx_ext = CMP_W'(req_data.entry_index);
      wr_en      = accept && (req_data.func == pliv_pkg::FUNC_WRITE) &&
                   (wr_idx_ext < CMP_W'(TABLE_DEPTH));
   end

   // Last knot searched: a count of zero acts as one, and the scan stays
   // inside the table.
   always_comb begin
      last_ext = CMP_W'(seg_cnt_ff);
      if (last_ext == '0) begin
         last_ext = CMP_W'(1);
      end
      if (last_ext > CMP_W'(TABLE_DEPTH - 1)) begin
         last_ext = CMP_W'(TABLE_DEPTH - 1);
      end
   end

   // Knot memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx_ext[IDX_W-1:0]] <= '{x: req_data.entry_x, y: req_data.entry_y};
      end
      row_ff     <= mem[rd_addr_ff];
      row_idx_ff <= rd_addr_ff;
   end

   // Segment differences and their magnitudes.
   always_comb begin
      num33   = 33'(pt_ff) - 33'(prev_ff.y);
      dx33    = 33'(cur_ff.x) - 33'(prev_ff.x);
      dy33    = 33'(cur_ff.y) - 33'(prev_ff.y);
      num_abs = num33[32] ? 33'(-num33) : 33'(num33);
      dx_abs  = dx33[32]  ? 33'(-dx33)  : 33'(dx33);
      dy_abs  = dy33[32]  ? 33'(-dy33)  : 33'(dy33);
   end

   // Final sum with saturation to the signed 32-bit range.
   always_comb begin
      q_big = (|quotient[63:34]) || (quotient[33] && (|quotient[32:0]));
      if (neg_ff) begin
         sum35 = 35'(prev_ff.x) - $signed({1'b0, quotient[33:0]});
      end else begin
         sum35 = 35'(prev_ff.x) + $signed({1'b0, quotient[33:0]});
      end
      if (q_big) begin
         sat_val = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (sum35[34:31] == 4'b0000 || sum35[34:31] == 4'b1111) begin
         sat_val = sum35[31:0];
      end else begin
         sat_val = sum35[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
   end

   // Query sequencer.
   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      rd_addr_in   = rd_addr_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      pt_in        = pt_ff;
      found_in     = found_ff;
      derr_in      = derr_ff;
      mag_num_in   = mag_num_ff;
      mag_dx_in    = mag_dx_ff;
      mag_dy_in    = mag_dy_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.func == pliv_pkg::FUNC_QUERY) begin
               pt_in      = req_data.query_point;
               last_in    = last_ext[IDX_W-1:0];
               rd_addr_in = '0;
               found_in   = 1'b0;
               derr_in    = 1'b0;
               state_in   = ST_FETCH;
            end
         end
         ST_FETCH: begin
            rd_addr_in = rd_addr_ff + IDX_W'(1);
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            // One knot leaves the read port each cycle.
            rd_addr_in = rd_addr_ff + IDX_W'(1);
            if (row_idx_ff == '0) begin
               prev_in = row_ff;
            end else if ($signed(pt_ff) < $signed(row_ff.y)) begin
               cur_in   = row_ff;
               found_in = 1'b1;
               state_in = ST_DIFF;
            end else if (row_idx_ff == last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_value: '0, found: 1'b0, divide_error: 1'b0};
               state_in     = ST_IDLE;
            end else begin
               prev_in = row_ff;
            end
         end
         ST_DIFF: begin
            mag_num_in = num_abs[31:0];
            mag_dx_in  = dx_abs[31:0];
            mag_dy_in  = dy_abs[31:0];
            neg_in     = (num33[32] ^ dx33[32] ^ dy33[32]) &&
                         (num33 != '0) && (dx33 != '0);
            if (dy33 == '0) begin
               derr_in      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_value: '0, found: 1'b1, divide_error: 1'b1};
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mag_num_ff * mag_dx_ff;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_value: sat_val, found: 1'b1, divide_error: 1'b0};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Shared divider for the interpolation quotient.
   pliv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_ISSUE),
      .dividend (prod_ff),
      .divisor  (mag_dy_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_cnt_ff   <= pliv_pkg::SEGMENT_COUNT_RST;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         derr_ff      <= 1'b0;
         rd_addr_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         derr_ff      <= derr_in;
         rd_addr_ff   <= rd_addr_in;
         if (csr_wr_en) begin
            seg_cnt_ff <= csr_wr_data;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      prev_ff    <= prev_in;
      cur_ff     <= cur_in;
      pt_ff      <= pt_in;
      mag_num_ff <= mag_num_in;
      mag_dx_ff  <= mag_dx_in;
      mag_dy_ff  <= mag_dy_in;
      neg_ff     <= neg_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A query never finishes in the cycle after another result.
   `PLIV_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid,
      "two result strobes in a row")
   // An accepted query holds the block busy.
   `PLIV_ASSERT_NEXT(a_query_busy, clock, reset,
      accept && req_data.func == pliv_pkg::FUNC_QUERY, busy,
      "query accepted but block not busy")
   // A write item leaves the block ready.
   `PLIV_ASSERT_NEXT(a_write_idle, clock, reset,
      accept && req_data.func == pliv_pkg::FUNC_WRITE, !busy && !rsp_valid,
      "write item started a query")
   // A divide fault comes with a found segment and a zero value.
   `PLIV_ASSERT_SAME(a_derr_value, clock, reset, rsp_valid && rsp_data.divide_error,
      rsp_data.found && rsp_data.result_value == '0,
      "divide fault with bad flags or value")
   // No segment found gives a zero value and no fault.
   `PLIV_ASSERT_SAME(a_miss_value, clock, reset, rsp_valid && !rsp_data.found,
      !rsp_data.divide_error && rsp_data.result_value == '0,
      "miss with nonzero value or fault")

endmodule

[test/piecewise_linear_inverse_lookup_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear inverse lookup checker
// Watches the item, result and register ports, keeps a private copy of the
// knot table and the segment count, predicts each lookup result and compares
// every result strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module piecewise_linear_inverse_lookup_checker #(
   parameter int DEPTH = pliv_pkg::TABLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  pliv_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  pliv_pkg::rsp_type          rsp_data,
   input  logic                       csr_wr_en,
   input  logic [pliv_pkg::CNT_W-1:0] csr_wr_data,
   output int                         mismatch_count,
   output int                         outstanding,
   output int                         results_checked
);
   import pliv_pkg::*;

   localparam longint SAT_HIGH  = 64'sd2147483647;
   localparam longint SAT_LOW   = -64'sd2147483648;
   localparam int     PRINT_CAP = 40;

   // Private copy of the block state.
   logic signed [31:0] knot_x [DEPTH];
   logic signed [31:0] knot_y [DEPTH];
   logic [CNT_W-1:0]   segment_count;

   // Lookup results still owed by the block, oldest first.
   rsp_type            lookup_q[$];
   rsp_type            oldest;

   initial begin
      mismatch_count  = 0;
      outstanding     = 0;
      results_checked = 0;
   end

   // Prints one line per mismatch (up to a cap) and counts every one.
   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) begin
         $display("%0t: lookup mismatch: %s", $time, what);
      end
      mismatch_count++;
   endtask

   // Scans the knots for the first y above the point and interpolates x on
   // that segment; the product is held at full width before the divide.
   function automatic rsp_type predict_lookup(input logic signed [31:0] point);
      rsp_type     outcome;
      int          last_knot;
      int          k;
      longint      pt;
      longint      x_lo;
      longint      x_hi;
      longint      y_lo;
      longint      y_hi;
      longint      num;
      longint      dx;
      longint      dy;
      longint      sum;
      logic [63:0] mag_num;
      logic [63:0] mag_dx;
      logic [63:0] mag_dy;
      logic [63:0] quot;
      logic        neg;
      outcome   = '0;
      last_knot = (segment_count == 0) ? 1 : int'(segment_count);
      if (last_knot > DEPTH - 1) begin
         last_knot = DEPTH - 1;
      end
      pt = longint'(point);
      k  = 1;
      while (!outcome.found && k <= last_knot) begin
         y_hi = longint'(knot_y[k]);
         if (pt < y_hi) begin
            outcome.found = 1'b1;
            y_lo = longint'(knot_y[k-1]);
            x_lo = longint'(knot_x[k-1]);
            x_hi = longint'(knot_x[k]);
            num  = pt - y_lo;
            dx   = x_hi - x_lo;
            dy   = y_hi - y_lo;
            if (dy == 0) begin
               // A flat segment cannot be inverted.
               outcome.divide_error = 1'b1;
            end else begin
               neg = ((num < 0) != (dx < 0)) != (dy < 0);
               if (num == 0 || dx == 0) begin
                  neg = 1'b0;
               end
               mag_num = (num < 0) ? -num : num;
               mag_dx  = (dx < 0) ? -dx : dx;
               mag_dy  = (dy < 0) ? -dy : dy;
               quot    = (mag_num * mag_dx) / mag_dy;
               if (quot > 64'h2_0000_0000) begin
                  sum = neg ? SAT_LOW : SAT_HIGH;
               end else begin
                  sum = neg ? x_lo - longint'(quot) : x_lo + longint'(quot);
                  if (sum > SAT_HIGH) begin
                     sum = SAT_HIGH;
                  end
                  if (sum < SAT_LOW) begin
                     sum = SAT_LOW;
                  end
               end
               outcome.result_value = sum[31:0];
            end
         end
         k++;
      end
      return outcome;
   endfunction

   // Everything is sampled at the rising edge: results are checked before a
   // new item is taken, so a result and an acceptance in one cycle both work.
   always @(posedge clock) begin
      if (reset) begin
         segment_count = SEGMENT_COUNT_RST;
         for (int k = 0; k < DEPTH; k++) begin
            knot_x[k] = '0;
            knot_y[k] = '0;
         end
         lookup_q.delete();
      end else begin
         // Result side.
         if (rsp_valid === 1'b1) begin
            if (lookup_q.size() == 0) begin
               report_mismatch($sformatf("result %h with no lookup pending", rsp_data));
            end else begin
               oldest = lookup_q.pop_front();
               if (rsp_data.result_value !== oldest.result_value) begin
                  report_mismatch($sformatf("result_value %h, expected %h",
                                            rsp_data.result_value, oldest.result_value));
               end
               if (rsp_data.found !== oldest.found) begin
                  report_mismatch($sformatf("found %b, expected %b",
                                            rsp_data.found, oldest.found));
               end
               if (rsp_data.divide_error !== oldest.divide_error) begin
                  report_mismatch($sformatf("divide_error %b, expected %b",
                                            rsp_data.divide_error, oldest.divide_error));
               end
               results_checked++;
            end
         end

         // Register side.
         if (csr_wr_en === 1'b1) begin
            segment_count = csr_wr_data;
         end

         // Item side: a write loads one knot, a query owes one result.
         if (start === 1'b1 && busy === 1'b0) begin
            if (req_data.func == FUNC_QUERY) begin
               lookup_q.push_back(predict_lookup(req_data.query_point));
            end else if (int'(req_data.entry_index) < DEPTH) begin
               knot_x[req_data.entry_index] = req_data.entry_x;
               knot_y[req_data.entry_index] = req_data.entry_y;
            end
         end
      end
      outstanding = lookup_q.size();
   end

endmodule

[test/piecewise_linear_inverse_lookup_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear inverse lookup testbench
// Drives knot writes and lookups into the block, first a directed set of
// corner cases, then random tables and query points under three pacing
// phases and many segment count settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module piecewise_linear_inverse_lookup_top_tb;
   import pliv_pkg::*;

   localparam int     KNOT_COUNT   = TABLE_DEPTH_DEF;
   localparam longint CYCLE_LIMIT  = 1500000;
   localparam int     DRAIN_CYCLES = 160;
   localparam int     PHASE_ITEMS  = 640;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   int               mismatch_count;
   int               outstanding;
   int               results_checked;

   int               sender_idle_pct;
   int               items_sent;
   int               lookups_sent;
   int               table_loads;
   longint           cycle_count;

   // What the stimulus knows of the table, used to aim query points and to
   // make sure no lookup touches a knot that was never written.
   bit                 knot_loaded [KNOT_COUNT];
   logic signed [31:0] knot_y_seen [KNOT_COUNT];

   piecewise_linear_inverse_lookup_top uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   piecewise_linear_inverse_lookup_checker lookup_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   // Clock and cycle counter.
   initial begin
      clock       = 1'b0;
      cycle_count = 0;
   end

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
   end

   // Watchdog for a hung block.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("Timed out after %0d cycles with %0d lookups pending.",
               cycle_count, outstanding);
      $display("** piecewise_linear_inverse_lookup_top: FAILED **");
      $finish;
   end

   // Presents one item at a falling edge, after random idle cycles with junk
   // on the bus, and returns at the rising edge that accepts it.
   task automatic issue(input req_type item);
      logic [127:0] scramble;
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         scramble = {$urandom, $urandom, $urandom, $urandom};
         start    = 1'b0;
         req_data = scramble[$bits(req_type)-1:0];
         @(negedge clock);
      end
      start    = 1'b1;
      req_data = item;
      @(posedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Writes one knot; the query field is don't-care and carries noise.
   task automatic put_knot(input logic [CNT_W-1:0] index, input logic [31:0] x,
                           input logic [31:0] y);
      req_type item;
      item             = '0;
      item.func        = FUNC_WRITE;
      item.entry_index = index;
      item.entry_x     = x;
      item.entry_y     = y;
      item.query_point = $urandom;
      issue(item);
      knot_loaded[index] = 1'b1;
      knot_y_seen[index] = y;
   endtask

   // Runs one lookup; the knot fields are don't-care and carry noise.
   task automatic ask(input logic [31:0] point);
      req_type item;
      item             = '0;
      item.func        = FUNC_QUERY;
      item.entry_index = CNT_W'($urandom);
      item.entry_x     = $urandom;
      item.entry_y     = $urandom;
      item.query_point = point;
      issue(item);
      lookups_sent++;
   endtask

   // Changes the segment count once the block has gone quiet.
   task automatic set_segment_count(input logic [CNT_W-1:0] value);
      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0 || busy !== 1'b0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Loads knots 0 through last_knot with mostly ascending y. Now and then a
   // segment is flat, descends or takes a big step that may wrap.
   task automatic load_table(input int last_knot);
      longint y_run;
      longint x_run;
      int     pick;
      y_run = longint'(int'($urandom_range(0, 32'h0200_0000))) - 64'sd16777216;
      x_run = longint'(int'($urandom));
      for (int k = 0; k <= last_knot; k++) begin
         pick = $urandom_range(0, 99);
         if (k > 0) begin
            if (pick < 4) begin
               y_run = y_run;
            end else if (pick < 7) begin
               y_run -= longint'($urandom_range(1, 32'h0010_0000));
            end else if (pick < 12) begin
               y_run += longint'($urandom_range(1, 32'h1000_0000));
            end else begin
               y_run += longint'($urandom_range(1, 32'h0010_0000));
            end
         end
         if ($urandom_range(0, 1) == 0) begin
            x_run = longint'(int'($urandom));
         end else begin
            x_run += longint'(int'($urandom_range(0, 32'h0004_0000))) - 64'sd131072;
         end
         put_knot(k[CNT_W-1:0], x_run[31:0], y_run[31:0]);
      end
      table_loads++;
   endtask

   // Picks a point near a knot, on a knot, at an extreme or anywhere.
   task automatic random_lookup(input int last_knot);
      longint point;
      int     pick;
      int     k;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, last_knot);
      if (pick < 55) begin
         point = longint'(knot_y_seen[k])
               + longint'(int'($urandom_range(0, 32'h0008_0000))) - 64'sd262144;
      end else if (pick < 70) begin
         point = longint'(knot_y_seen[k]);
      end else if (pick < 76) begin
         point = ($urandom_range(0, 1) == 0) ? 64'sh8000_0000 : 64'sh7fff_ffff;
      end else begin
         point = longint'(int'($urandom));
      end
      ask(point[31:0]);
   endtask

   // One pacing phase: a run of count settings, each with a table that is
   // freshly loaded at random (always when a needed knot is still blank) and a burst
   // of lookups salted with stray knot writes.
   task automatic run_phase(input int idle_pct, input int budget, input int first_count);
      int stop_at;
      int count_value;
      int last_knot;
      int pick;
      bit need_load;
      sender_idle_pct = idle_pct;
      stop_at         = items_sent + budget;
      count_value     = first_count;
      while (items_sent < stop_at) begin
         set_segment_count(count_value[CNT_W-1:0]);
         last_knot = (count_value == 0) ? 1 : count_value;
         need_load = ($urandom_range(0, 99) < 60);
         for (int k = 0; k <= last_knot; k++) begin
            if (!knot_loaded[k]) begin
               need_load = 1'b1;
            end
         end
         if (need_load) begin
            load_table(last_knot);
         end
         repeat ($urandom_range(12, 40)) begin
            if ($urandom_range(0, 99) < 8) begin
               put_knot(CNT_W'($urandom_range(0, KNOT_COUNT - 1)), $urandom, $urandom);
            end
            random_lookup(last_knot);
         end
         // Mostly short scans, sometimes long ones and the extremes.
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            count_value = 0;
         end else if (pick < 12) begin
            count_value = 63;
         end else if (pick < 25) begin
            count_value = $urandom_range(9, 62);
         end else begin
            count_value = $urandom_range(1, 8);
         end
      end
   endtask

   // Stimulus.
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      sender_idle_pct = 0;
      items_sent      = 0;
      lookups_sent    = 0;
      table_loads     = 0;
      for (int k = 0; k < KNOT_COUNT; k++) begin
         knot_loaded[k] = 1'b0;
         knot_y_seen[k] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed corners with the reset count of one segment.
      put_knot(6'd0, 32'h0000_0000, 32'h0000_0000);
      put_knot(6'd1, 32'h0001_0000, 32'h0002_0000);
      ask(32'h0001_0000);                        // midpoint of the segment
      ask(32'h0002_0000);                        // equal to the top knot: none above
      ask(32'hffff_0000);                        // below knot 0: extrapolated
      ask(32'h7fff_ffff);                        // largest point: none above
      ask(32'h8000_0000);                        // smallest point: far extrapolation
      put_knot(6'd1, 32'h0001_0000, 32'h0000_0000);
      ask(32'hffff_fffb);                        // flat segment: divide error
      put_knot(6'd1, 32'h8000_0000, 32'h0000_0001);
      ask(32'h8000_0000);                        // huge quotient, saturates high
      put_knot(6'd0, 32'h7fff_ffff, 32'h0000_0000);
      put_knot(6'd1, 32'h0000_0000, 32'h0000_0100);
      ask(32'hffff_ff00);                        // sum well past the top, clamped
      put_knot(6'd0, 32'h8000_0000, 32'h0000_0000);
      put_knot(6'd1, 32'h7fff_ffff, 32'h0000_0001);
      ask(32'h8000_0000);                        // huge quotient, saturates low
      put_knot(6'd0, 32'h0003_0000, 32'h7fff_ffff);
      put_knot(6'd1, 32'h0001_0000, 32'h0001_0000);
      ask(32'h0000_0000);                        // descending knots
      put_knot(6'd63, 32'h7fff_ffff, 32'hffff_ffff);

      // Random phases: light sender gaps, heavy gaps, then back to back.
      run_phase(13, PHASE_ITEMS, 63);
      run_phase(47, PHASE_ITEMS, 0);
      run_phase(0, PHASE_ITEMS, 1);

      @(negedge clock);
      start = 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d lookups, %0d table loads); %0d results checked.",
               items_sent, lookups_sent, table_loads, results_checked);
      $display("Segment counts from 0 to 63 under three pacing phases; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("** piecewise_linear_inverse_lookup_top: PASSED **");
      end else begin
         $display("** piecewise_linear_inverse_lookup_top: FAILED **");
      end
      $finish;
   end

endmodule
